// File: hw/rtl/psd_pkg.sv
// Package for the point to segment squared distance block.
// Holds the result width, the saturation and limit constants and the region codes.
// No dependencies.
`default_nettype none

package psd_pkg;

   localparam int DIST_W = 50;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam logic [DIST_W-1:0] LIMIT_RESET = DIST_W'(4194304);

   typedef enum logic [1:0] {
      REGION_START    = 2'd0,
      REGION_END      = 2'd1,
      REGION_INTERIOR = 2'd2
   } region_type;

endpackage

`default_nettype wire

// File: hw/rtl/psd_if.sv
// Valid/ready channel interfaces for the point to segment distance block.
// Depends on psd_pkg for the result width.
`default_nettype none

interface psd_req_if #(
   parameter int COORD_WIDTH   = 16,
   parameter int FRACTION_BITS = 8
);
   logic                                          valid;
   logic                                          ready;
   logic signed [COORD_WIDTH+FRACTION_BITS-1:0]   point_x;
   logic signed [COORD_WIDTH+FRACTION_BITS-1:0]   point_y;
   logic signed [COORD_WIDTH-1:0]                 start_x;
   logic signed [COORD_WIDTH-1:0]                 start_y;
   logic signed [COORD_WIDTH-1:0]                 end_x;
   logic signed [COORD_WIDTH-1:0]                 end_y;

   modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
                   input ready);
   modport sink (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
                 output ready);
endinterface

interface psd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psd_pkg::DIST_W-1:0]    dist_sq;
   logic [1:0]                    region;
   logic                          near;

   modport source (output valid, dist_sq, region, near, input ready);
   modport sink (input valid, dist_sq, region, near, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/point_segment_distance_sq_top.sv
// Top level of the point to segment squared distance pipeline.
// Depends on psd_pkg and on the channel interfaces in psd_if.sv.
//
//   channel   direction   transaction contents
//   req_if    in          point_x, point_y, start_x, start_y, end_x, end_y
//   rsp_if    out         dist_sq, region, near
//   csr       in          near_limit_sq (write only)
//
// One transaction enters per cycle while the output is not stalled; the restoring
// divider resolves one quotient bit per stage.
// Reset clears the valid bits and loads the near limit with 8*8 map units squared.
// Each stage advances when it is empty or the stage after it advances, so a stalled
// output fills the pipeline bubbles first and drops or repeats nothing.
`default_nettype none

module point_segment_distance_sq_top #(
   parameter int COORD_WIDTH   = 16,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   psd_req_if.sink                            req_if,
   psd_rsp_if.source                          rsp_if,
   input  wire logic                          csr_wr_en,
   input  wire logic [psd_pkg::DIST_W-1:0]    csr_wr_data
);

   localparam int CW   = COORD_WIDTH;
   localparam int PW   = COORD_WIDTH + FRACTION_BITS;
   localparam int AW   = PW + 1;
   localparam int BW   = CW + 1;
   localparam int PRW  = AW + BW;
   localparam int NW   = PRW + 1;
   localparam int DW   = 2 * CW + 1;
   localparam int QW   = CW;
   localparam int MW   = CW + DW;
   localparam int EW   = AW + 1;
   localparam int SW   = 2 * EW + 1;
   localparam int CMPW = (SW > psd_pkg::DIST_W) ? SW : psd_pkg::DIST_W;

   typedef struct packed {
      logic [DW-1:0]         den;
      logic                  neg_x;
      logic                  neg_y;
      psd_pkg::region_type   region;
      logic signed [AW-1:0]  acx;
      logic signed [AW-1:0]  acy;
      logic signed [AW-1:0]  bcx;
      logic signed [AW-1:0]  bcy;
   } side_type;

   typedef struct packed {
      logic [DW-1:0] rem;
      logic [QW-1:0] low;
      logic [QW-1:0] quo;
   } lane_type;

   function automatic lane_type div_step(input lane_type l, input logic [DW-1:0] d);
      logic [DW:0] trial;
      lane_type    r;
      trial = {l.rem, l.low[QW-1]};
      r.low = l.low << 1;
      if (trial >= {1'b0, d}) begin
         r.rem = DW'(trial - {1'b0, d});
         r.quo = {l.quo[QW-2:0], 1'b1};
      end else begin
         r.rem = trial[DW-1:0];
         r.quo = {l.quo[QW-2:0], 1'b0};
      end
      return r;
   endfunction

   logic [psd_pkg::DIST_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= psd_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   logic en1, en2, en3, en4, en5, en6, en_out;
   logic [QW-1:0] en_d;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, out_v_ff;
   logic [QW-1:0] dv_ff;

   // Stage 1: differences.
   logic signed [AW-1:0] acx_ff, acy_ff, bcx_ff, bcy_ff;
   logic signed [BW-1:0] abx_ff, aby_ff;
   logic signed [AW-1:0] acx_in, acy_in, bcx_in, bcy_in, aqx, aqy, bqx, bqy;
   logic signed [BW-1:0] abx_in, aby_in;

   always_comb begin
      aqx    = AW'(req_if.start_x) <<< FRACTION_BITS;
      aqy    = AW'(req_if.start_y) <<< FRACTION_BITS;
      bqx    = AW'(req_if.end_x) <<< FRACTION_BITS;
      bqy    = AW'(req_if.end_y) <<< FRACTION_BITS;
      acx_in = AW'(req_if.point_x) - aqx;
      acy_in = AW'(req_if.point_y) - aqy;
      bcx_in = AW'(req_if.point_x) - bqx;
      bcy_in = AW'(req_if.point_y) - bqy;
      abx_in = BW'(req_if.end_x) - BW'(req_if.start_x);
      aby_in = BW'(req_if.end_y) - BW'(req_if.start_y);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         acx_ff <= acx_in;
         acy_ff <= acy_in;
         bcx_ff <= bcx_in;
         bcy_ff <= bcy_in;
         abx_ff <= abx_in;
         aby_ff <= aby_in;
      end
   end

   // Stage 2: products.
   logic signed [PRW-1:0]  pax_ff, pay_ff;
   logic signed [2*BW-1:0] pbx_ff, pby_ff;
   logic signed [AW-1:0]   acx2_ff, acy2_ff, bcx2_ff, bcy2_ff;
   logic signed [BW-1:0]   abx2_ff, aby2_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         pax_ff  <= PRW'(acx_ff) * PRW'(abx_ff);
         pay_ff  <= PRW'(acy_ff) * PRW'(aby_ff);
         pbx_ff  <= (2*BW)'(abx_ff) * (2*BW)'(abx_ff);
         pby_ff  <= (2*BW)'(aby_ff) * (2*BW)'(aby_ff);
         acx2_ff <= acx_ff;
         acy2_ff <= acy_ff;
         bcx2_ff <= bcx_ff;
         bcy2_ff <= bcy_ff;
         abx2_ff <= abx_ff;
         aby2_ff <= aby_ff;
      end
   end

   // Stage 3: dot products.
   logic signed [NW-1:0] num_ff;
   logic [DW-1:0]        den_ff;
   logic signed [AW-1:0] acx3_ff, acy3_ff, bcx3_ff, bcy3_ff;
   logic signed [BW-1:0] abx3_ff, aby3_ff;
   logic [2*BW-1:0]      den_sum;

   assign den_sum = pbx_ff + pby_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         num_ff  <= NW'(pax_ff) + NW'(pay_ff);
         den_ff  <= den_sum[DW-1:0];
         acx3_ff <= acx2_ff;
         acy3_ff <= acy2_ff;
         bcx3_ff <= bcx2_ff;
         bcy3_ff <= bcy2_ff;
         abx3_ff <= abx2_ff;
         aby3_ff <= aby2_ff;
      end
   end

   // Stage 4: region decision and divider operands.
   side_type             s4_in, s4_ff;
   lane_type             l4x_ff, l4y_ff;
   logic [CW-1:0]        magx, magy;
   logic [MW-1:0]        mx_in, my_in;
   logic signed [NW-1:0] den_ext;

   always_comb begin
      den_ext = $signed(NW'(den_ff));
      s4_in.den   = den_ff;
      s4_in.neg_x = abx3_ff[BW-1];
      s4_in.neg_y = aby3_ff[BW-1];
      s4_in.acx   = acx3_ff;
      s4_in.acy   = acy3_ff;
      s4_in.bcx   = bcx3_ff;
      s4_in.bcy   = bcy3_ff;
      if (den_ff == '0 || num_ff[NW-1] || num_ff == '0) begin
         s4_in.region = psd_pkg::REGION_START;
      end else if (num_ff >= den_ext) begin
         s4_in.region = psd_pkg::REGION_END;
      end else begin
         s4_in.region = psd_pkg::REGION_INTERIOR;
      end
      magx  = abx3_ff[BW-1] ? CW'(-abx3_ff) : CW'(abx3_ff);
      magy  = aby3_ff[BW-1] ? CW'(-aby3_ff) : CW'(aby3_ff);
      mx_in = MW'(magx) * MW'(num_ff[DW-1:0]);
      my_in = MW'(magy) * MW'(num_ff[DW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_ff      <= s4_in;
         l4x_ff.rem <= mx_in[MW-1:QW];
         l4x_ff.low <= mx_in[QW-1:0];
         l4x_ff.quo <= '0;
         l4y_ff.rem <= my_in[MW-1:QW];
         l4y_ff.low <= my_in[QW-1:0];
         l4y_ff.quo <= '0;
      end
   end

   // Divider: one quotient bit per stage for both lanes.
   lane_type dx_ff [QW];
   lane_type dy_ff [QW];
   side_type ds_ff [QW];

   for (genvar i = 0; i < QW; i++) begin : g_div
      lane_type src_x, src_y;
      side_type src_s;
      logic     src_v;
      logic     next_en;

      if (i == 0) begin : g_first
         always_comb begin
            src_x = l4x_ff;
            src_y = l4y_ff;
            src_s = s4_ff;
            src_v = v4_ff;
         end
      end else begin : g_rest
         always_comb begin
            src_x = dx_ff[i-1];
            src_y = dy_ff[i-1];
            src_s = ds_ff[i-1];
            src_v = dv_ff[i-1];
         end
      end

      if (i == QW - 1) begin : g_last
         assign next_en = en5;
      end else begin : g_mid
         assign next_en = en_d[i+1];
      end

      assign en_d[i] = !dv_ff[i] || next_en;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[i] <= 1'b0;
         end else if (en_d[i]) begin
            dv_ff[i] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en_d[i]) begin
            dx_ff[i] <= div_step(src_x, src_s.den);
            dy_ff[i] <= div_step(src_y, src_s.den);
            ds_ff[i] <= src_s;
         end
      end
   end

   // Stage 5: error vector magnitudes.
   logic signed [EW-1:0]  qx, qy, ex, ey;
   logic [EW-1:0]         mgx_in, mgy_in, mgx_ff, mgy_ff;
   psd_pkg::region_type   r5_ff, r6_ff;
   side_type              s5;

   always_comb begin
      s5 = ds_ff[QW-1];
      qx = EW'($signed({1'b0, dx_ff[QW-1].quo}));
      qy = EW'($signed({1'b0, dy_ff[QW-1].quo}));
      if (s5.neg_x) begin
         qx = -qx;
      end
      if (s5.neg_y) begin
         qy = -qy;
      end
      case (s5.region)
         psd_pkg::REGION_START: begin
            ex = EW'(s5.acx);
            ey = EW'(s5.acy);
         end
         psd_pkg::REGION_END: begin
            ex = EW'(s5.bcx);
            ey = EW'(s5.bcy);
         end
         default: begin
            ex = EW'(s5.acx) - qx;
            ey = EW'(s5.acy) - qy;
         end
      endcase
      mgx_in = ex[EW-1] ? EW'(-ex) : EW'(ex);
      mgy_in = ey[EW-1] ? EW'(-ey) : EW'(ey);
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         mgx_ff <= mgx_in;
         mgy_ff <= mgy_in;
         r5_ff  <= s5.region;
      end
   end

   // Stage 6: squares.
   logic [2*EW-1:0] sqx_ff, sqy_ff;

   always_ff @(posedge clock) begin
      if (en6) begin
         sqx_ff <= (2*EW)'(mgx_ff) * (2*EW)'(mgx_ff);
         sqy_ff <= (2*EW)'(mgy_ff) * (2*EW)'(mgy_ff);
         r6_ff  <= r5_ff;
      end
   end

   // Output register: sum, saturation and limit compare.
   logic [CMPW-1:0]             sum_ext;
   logic [psd_pkg::DIST_W-1:0]  dist_in, dist_ff;
   logic [1:0]                  region_ff;
   logic                        near_ff;

   always_comb begin
      sum_ext = CMPW'(SW'(sqx_ff) + SW'(sqy_ff));
      if (sum_ext > CMPW'(psd_pkg::DIST_MAX)) begin
         dist_in = psd_pkg::DIST_MAX;
      end else begin
         dist_in = sum_ext[psd_pkg::DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         dist_ff   <= dist_in;
         region_ff <= r6_ff;
         near_ff   <= dist_in < limit_ff;
      end
   end

   assign en_out = !out_v_ff || rsp_if.ready;
   assign en6    = !v6_ff || en_out;
   assign en5    = !v5_ff || en6;
   assign en4    = !v4_ff || en_d[0];
   assign en3    = !v3_ff || en4;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         v5_ff    <= 1'b0;
         v6_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_if.valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
         if (en5) begin
            v5_ff <= dv_ff[QW-1];
         end
         if (en6) begin
            v6_ff <= v5_ff;
         end
         if (en_out) begin
            out_v_ff <= v6_ff;
         end
      end
   end

   assign req_if.ready   = en1;
   assign rsp_if.valid   = out_v_ff;
   assign rsp_if.dist_sq = dist_ff;
   assign rsp_if.region  = region_ff;
   assign rsp_if.near    = near_ff;

   // The remainder left by the last divider stage of an interior division stays below the divisor.
   a_rem_x: assert property (@(posedge clock) disable iff (reset)
      dv_ff[QW-1] && ds_ff[QW-1].region == psd_pkg::REGION_INTERIOR
      |-> dx_ff[QW-1].rem < ds_ff[QW-1].den)
      else $error("x lane remainder not below divisor");

   a_rem_y: assert property (@(posedge clock) disable iff (reset)
      dv_ff[QW-1] && ds_ff[QW-1].region == psd_pkg::REGION_INTERIOR
      |-> dy_ff[QW-1].rem < ds_ff[QW-1].den)
      else $error("y lane remainder not below divisor");

   // An interior projection never has a zero-length segment behind it.
   a_interior_den: assert property (@(posedge clock) disable iff (reset)
      v4_ff && s4_ff.region == psd_pkg::REGION_INTERIOR |-> s4_ff.den != '0)
      else $error("interior region with zero-length segment");

endmodule

`default_nettype wire

// File: bench/tb_point_segment_distance_sq_top.sv
// Self-checking testbench for point_segment_distance_sq_top: drives geometry queries,
// predicts squared distance, region and near flag, and compares every response.
// Depends on psd_pkg and on the channel interfaces in psd_if.sv.
`default_nettype none

module tb_point_segment_distance_sq_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = 16;
   localparam int FB = 8;
   localparam int PW = CW + FB;
   localparam int DIST_W = psd_pkg::DIST_W;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [DIST_W-1:0]    dist_sq;
      psd_pkg::region_type  region;
      logic                 near;
   } distance_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [DIST_W-1:0] csr_wr_data = '0;

   psd_req_if #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) req_if ();
   psd_rsp_if rsp_if ();

   point_segment_distance_sq_top #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) DUT (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   distance_result_type expected_results[$];
   logic [DIST_W-1:0] near_limit = psd_pkg::LIMIT_RESET;
   int error_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int idle_cycles = 0;
   int region_seen[3] = '{0, 0, 0};
   int rsp_wait = 0;
   int seen_count = 0;
   bit hold_off = 1'b0;
   bit random_stall = 1'b0;

   initial begin
      req_if.valid = 1'b0;
      req_if.point_x = '0;
      req_if.point_y = '0;
      req_if.start_x = '0;
      req_if.start_y = '0;
      req_if.end_x = '0;
      req_if.end_y = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic logic [DIST_W-1:0] clamp_sq_len(longint ex, longint ey);
      longint unsigned mx, my, s;
      mx = (ex < 0) ? -ex : ex;
      my = (ey < 0) ? -ey : ey;
      s = mx * mx + my * my;
      return (s > 64'(psd_pkg::DIST_MAX)) ? psd_pkg::DIST_MAX : s[DIST_W-1:0];
   endfunction

   function automatic distance_result_type predict_distance(
         logic signed [PW-1:0] px_in, logic signed [PW-1:0] py_in,
         logic signed [CW-1:0] ax_in, logic signed [CW-1:0] ay_in,
         logic signed [CW-1:0] bx_in, logic signed [CW-1:0] by_in);
      distance_result_type r;
      longint px, py, ax, ay, bx, by, acx, acy, abx, aby, num, den, dx, dy;
      px = px_in;
      py = py_in;
      ax = ax_in;
      ay = ay_in;
      bx = bx_in;
      by = by_in;
      acx = px - (ax <<< FB);
      acy = py - (ay <<< FB);
      abx = bx - ax;
      aby = by - ay;
      num = acx * abx + acy * aby;
      den = abx * abx + aby * aby;
      if (den == 0 || num <= 0) begin
         r.dist_sq = clamp_sq_len(acx, acy);
         r.region = psd_pkg::REGION_START;
      end else if (num >= den) begin
         r.dist_sq = clamp_sq_len(px - (bx <<< FB), py - (by <<< FB));
         r.region = psd_pkg::REGION_END;
      end else begin
         dx = (ax <<< FB) + (abx * num) / den;
         dy = (ay <<< FB) + (aby * num) / den;
         r.dist_sq = clamp_sq_len(px - dx, py - dy);
         r.region = psd_pkg::REGION_INTERIOR;
      end
      r.near = (r.dist_sq < near_limit);
      return r;
   endfunction

   task automatic send_query(logic signed [PW-1:0] px, logic signed [PW-1:0] py,
                             logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                             logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 2) == 0) gap = 0;
      repeat (gap) @(negedge clock);
      req_if.point_x = px;
      req_if.point_y = py;
      req_if.start_x = ax;
      req_if.start_y = ay;
      req_if.end_x = bx;
      req_if.end_y = by;
      req_if.valid = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      expected_results.push_back(predict_distance(px, py, ax, ay, bx, by));
      sent_count++;
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   task automatic write_near_limit(logic [DIST_W-1:0] value);
      wait (expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_data = value;
      csr_wr_en = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
      near_limit = value;
   endtask

   // Response side: a random wait before each transaction while random_stall is set, or a long hold-off.
   always @(negedge clock) begin
      if (checked_count != seen_count) begin
         seen_count = checked_count;
         rsp_wait = random_stall ? $urandom_range(0, 16) : 0;
      end
      if (hold_off) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_wait = rsp_wait - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      distance_result_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected transaction: dist_sq %0d", rsp_if.dist_sq);
            error_count++;
         end else begin
            e = expected_results.pop_front();
            checked_count++;
            region_seen[e.region]++;
            if (rsp_if.dist_sq !== e.dist_sq) begin
               $error("dist_sq expected %0d actual %0d", e.dist_sq, rsp_if.dist_sq);
               error_count++;
            end
            if (rsp_if.region !== e.region) begin
               $error("region expected %0d actual %0d", e.region, rsp_if.region);
               error_count++;
            end
            if (rsp_if.near !== e.near) begin
               $error("near expected %0d actual %0d", e.near, rsp_if.near);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic test_extremes();
      logic signed [PW-1:0] pmax, pmin;
      pmax = {1'b0, {(PW-1){1'b1}}};
      pmin = {1'b1, {(PW-1){1'b0}}};
      send_query(0, 0, 0, 0, 0, 0);
      send_query(pmax, pmax, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_query(pmin, pmin, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_query(pmax, pmin, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
      send_query(pmin, pmax, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
      send_query(-1, -1, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
      send_query(pmax, pmax, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
   endtask

   task automatic test_regions();
      send_query(-5 * 256, 3 * 256, 0, 0, 10, 0);
      send_query(0, 7 * 256, 0, 0, 10, 0);
      send_query(15 * 256, -2 * 256, 0, 0, 10, 0);
      send_query(10 * 256, 4 * 256, 0, 0, 10, 0);
      send_query(5 * 256 + 77, 3 * 256 + 5, 0, 0, 10, 0);
      send_query(1000, 333, 1, 2, 7, 5);
      send_query(-1000, 333, -1, 2, -7, -5);
      send_query(7 * 256, 7 * 256 + 255, 0, 0, 3, 3);
      send_query(300, -900, 4, -4, 4, -4);
      send_query(2 * 256, 0, 0, 0, 0, 0);
      send_query(3 * 256, 1, 0, 0, 20, 30);
   endtask

   task automatic send_random_query();
      logic signed [PW-1:0] px, py;
      logic signed [CW-1:0] ax, ay, bx, by;
      int span;
      case ($urandom_range(0, 3))
         0: begin
            ax = $urandom;
            ay = $urandom;
            bx = $urandom;
            by = $urandom;
            px = $urandom;
            py = $urandom;
         end
         1: begin
            span = $urandom_range(0, 40);
            ax = $urandom_range(0, 200) - 100;
            ay = $urandom_range(0, 200) - 100;
            bx = ax + $urandom_range(0, 2 * span) - span;
            by = ay + $urandom_range(0, 2 * span) - span;
            px = (ax <<< FB) + $urandom_range(0, 12000) - 6000;
            py = (ay <<< FB) + $urandom_range(0, 12000) - 6000;
         end
         2: begin
            ax = $urandom;
            ay = $urandom;
            bx = ax;
            by = ay;
            px = $urandom;
            py = $urandom;
         end
         default: begin
            ax = $urandom;
            ay = $urandom;
            bx = $urandom;
            by = $urandom;
            px = PW'((PW'(ax) + PW'(bx)) <<< (FB - 1)) + $urandom_range(0, 4096) - 2048;
            py = PW'((PW'(ay) + PW'(by)) <<< (FB - 1)) + $urandom_range(0, 4096) - 2048;
         end
      endcase
      send_query(px, py, ax, ay, bx, by);
   endtask

   task automatic test_near_limits();
      write_near_limit('0);
      repeat (15) send_random_query();
      write_near_limit(psd_pkg::DIST_MAX);
      repeat (15) send_random_query();
      send_query(0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      write_near_limit(DIST_W'(65536));
      send_query(255, 0, 0, 0, 0, 0);
      send_query(256, 0, 0, 0, 0, 0);
      send_query(257, 0, 0, 0, 0, 0);
      write_near_limit(DIST_W'({$urandom, $urandom}));
      repeat (20) send_random_query();
      write_near_limit(psd_pkg::LIMIT_RESET);
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         repeat (60) send_random_query();
         begin
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
      join
   endtask

   task automatic test_random_stream();
      random_stall = 1'b1;
      repeat (250) send_random_query();
      random_stall = 1'b0;
      repeat (150) send_random_query();
      random_stall = 1'b1;
      repeat (100) send_random_query();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      test_regions();
      test_near_limits();
      test_backpressure();
      test_random_stream();
      wait (expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d queries, checked %0d transactions", sent_count, checked_count);
      $display("Regions start/end/interior: %0d/%0d/%0d",
               region_seen[0], region_seen[1], region_seen[2]);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
